/* hdl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/cle_pkg.sv */
package cle_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STORE_BYTES = 10;
  localparam int STORE_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERROR_TIMEOUT = 2'd0,
    CFG_REPLY_DELAY   = 2'd1,
    CFG_RETRY_DELAY   = 2'd2,
    CFG_IDLE_LIMIT    = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] RST_ERROR_TIMEOUT = 16'd100;
  localparam logic [15:0] RST_REPLY_DELAY   = 16'd10;
  localparam logic [15:0] RST_RETRY_DELAY   = 16'd20;
  localparam logic [7:0]  RST_IDLE_LIMIT    = 8'hFE;
  localparam logic [15:0] RST_REPLY_COUNT   = 16'd100;

  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] SOF_RX     = 8'h5A;
  localparam logic [7:0] SOF_TX     = 8'hA5;
  localparam logic [7:0] ID_HS      = 8'hE1;
  localparam logic [7:0] ID_DATA    = 8'hD2;
  localparam logic [7:0] LEN_HS     = 8'h04;
  localparam logic [7:0] LEN_DATA   = 8'h06;
  localparam logic [7:0] SPD_ECO    = 8'h00;
  localparam logic [7:0] SPD_MAX    = 8'h0e;
  localparam logic [7:0] SPD_MAX4   = 8'h0f;
  localparam logic [7:0] SPD_OTHER  = 8'h10;
  localparam logic [7:0] DATA_FILL  = 8'd135;
  localparam logic [7:0] PROT_LOW   = 8'h00;
  localparam logic [7:0] PROT_MID   = 8'h40;
  localparam logic [7:0] PROT_HIGH  = 8'hC0;
  localparam logic [7:0] CODE_LIMIT = 8'd7;

  localparam logic [2:0] SPEED_STOP = 3'd0;
  localparam logic [2:0] SPEED_ECO  = 3'd1;
  localparam logic [2:0] SPEED_MAX  = 3'd2;
  localparam logic [2:0] SPEED_MAX4 = 3'd3;
  localparam logic [1:0] PROT_CODE_LOW = 2'd0;
  localparam logic [1:0] PROT_CODE_MID = 2'd1;

  localparam int MIN_BYTES  = 3;
  localparam int HS_BYTES   = 8;
  localparam int DATA_BYTES = 10;
  localparam int CRC7_AT    = 7;
  localparam int CRC9_AT    = 9;

  localparam logic [2:0] TX_LAST_POS = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic [2:0] speed_level;
    logic [1:0] protect_level;
    logic [7:0] rx_delay_load;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] send_seq;
    logic       rx_enable;
    logic       comm_error;
    logic [2:0] comp_error;
    logic       handshake_done;
    logic       frame_accepted;
  } out_item_t;

  // One queued job: either a single status result or a whole transmit frame.
  typedef struct packed {
    logic       send;
    logic [2:0] speed_level;
    logic [1:0] protect_level;
    logic [7:0] send_seq;
    logic       rx_enable;
    logic       comm_error;
    logic [2:0] comp_error;
    logic       handshake_done;
    logic       frame_accepted;
  } job_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hdl/compressor_link_frame_engine_unit.sv */
// Channel   Handshake            Payload
// input     in_push / in_full    in_item   (tick or received frame byte)
// result    out_pop / out_empty  out_item  (status, transmit frame byte)
// config    cfg_we               cfg_index, cfg_data
//
// One item is taken per cycle until the job queue between front and back fills.
// A byte or a quiet tick gives one result; a sending tick gives eight results,
// one per cycle from the back end while out_pop is held; meanwhile new items still enter the job queue.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// A stalled result side fills the job queue and then raises in_full.
`include "assert_macros.svh"

module compressor_link_frame_engine_unit import cle_pkg::*; #(
  parameter int FRAME_BYTES = 10,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic in_acc;
  job_t front_job, q_data;
  logic q_empty, q_pop;

  // Accept an item whenever the queue has room.
  assign in_acc = in_push && !in_full;

  // Front: classify the item, advance link state, build one job.
  cle_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (in_acc),
    .item      (in_item),
    .job       (front_job)
  );

  // Queue: hold jobs while the result side stalls.
  cle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .wdata (front_job),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  // Back: expand each job into its results, computing the frame CRC serially.
  cle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // A result that does not end its item must be a frame byte.
  `ASSERT_NEVER(a_mid_is_tx, clk, rst_n, !out_empty && !out_item.tx_last && !out_item.tx_valid, "non-final result without frame byte")
  // A frame is only accepted once the link is up.
  `ASSERT_NEVER(a_acc_link, clk, rst_n, !out_empty && out_item.frame_accepted && !out_item.handshake_done, "accepted frame without handshake")
  // A frame in progress keeps the result side busy.
  `ASSERT_AT(a_frame_cont, clk, rst_n, (out_pop && !out_empty && !out_item.tx_last) |=> !out_empty, "frame broken off")

endmodule

/* hdl/cle_front.sv */
module cle_front import cle_pkg::*; #(
  parameter int FRAME_BYTES = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  in_item_t              item,
  output job_t                  job
);

  localparam int IDX_W = $clog2(FRAME_BYTES + 1);

  logic [15:0] err_timeout_r, reply_delay_r, retry_delay_r;
  logic [7:0]  idle_limit_r;

  logic        link_r, link_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] reply_r, reply_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic [15:0] silence_r, silence_nxt;
  logic [7:0]  reen_r, reen_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt, c7_r, c7_nxt, c9_r, c9_nxt;
  logic        eflag_r, eflag_nxt;
  logic [2:0]  code_r, code_nxt;
  logic        rx_on_r, rx_on_nxt;
  logic [7:0]  frame_r [STORE_BYTES];
  logic [7:0]  frame_nxt [STORE_BYTES];
  logic        pass, send;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_timeout_r <= RST_ERROR_TIMEOUT;
      reply_delay_r <= RST_REPLY_DELAY;
      retry_delay_r <= RST_RETRY_DELAY;
      idle_limit_r  <= RST_IDLE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ERROR_TIMEOUT: err_timeout_r <= cfg_data;
        CFG_REPLY_DELAY:   reply_delay_r <= cfg_data;
        CFG_RETRY_DELAY:   retry_delay_r <= cfg_data;
        CFG_IDLE_LIMIT:    idle_limit_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    link_nxt    = link_r;
    seq_nxt     = seq_r;
    reply_nxt   = reply_r;
    idle_nxt    = idle_r;
    silence_nxt = silence_r;
    reen_nxt    = reen_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    c7_nxt      = c7_r;
    c9_nxt      = c9_r;
    eflag_nxt   = eflag_r;
    code_nxt    = code_r;
    rx_on_nxt   = rx_on_r;
    frame_nxt   = frame_r;
    pass        = 1'b0;
    send        = 1'b0;
    if (acc) begin
      if (item.mode) begin
        if (rx_on_r) begin
          if (idx_r < IDX_W'(FRAME_BYTES)) begin
            if (idx_r < IDX_W'(STORE_BYTES)) begin
              frame_nxt[idx_r[STORE_IDX_W-1:0]] = item.rx_byte;
            end
            crc_nxt = crc_step(crc_r, item.rx_byte);
            idx_nxt = idx_r + IDX_W'(1);
            if (idx_nxt == IDX_W'(CRC7_AT)) c7_nxt = crc_nxt;
            if (idx_nxt == IDX_W'(CRC9_AT)) c9_nxt = crc_nxt;
          end
          if (item.rx_last) begin
            // Judge the frame on its byte count and captured checks.
            if (idx_nxt >= IDX_W'(MIN_BYTES) && frame_nxt[0] == SOF_RX) begin
              if (!link_r) begin
                if (idx_nxt >= IDX_W'(HS_BYTES) && frame_nxt[1] == ID_HS &&
                    frame_nxt[2] == LEN_HS && c7_nxt == frame_nxt[7]) begin
                  link_nxt = 1'b1;
                  pass     = 1'b1;
                end
              end else if (idx_nxt >= IDX_W'(DATA_BYTES) && frame_nxt[1] == ID_DATA &&
                           frame_nxt[2] == LEN_DATA && c9_nxt == frame_nxt[9]) begin
                code_nxt = (frame_nxt[8] < CODE_LIMIT) ? frame_nxt[8][2:0] : 3'd0;
                pass     = 1'b1;
              end
            end
            if (pass) begin
              silence_nxt = err_timeout_r;
              reply_nxt   = reply_delay_r;
              eflag_nxt   = 1'b0;
            end
            idx_nxt = '0;
            crc_nxt = '0;
          end
        end
      end else begin
        if (item.rx_delay_load != 8'd0) reen_nxt = item.rx_delay_load;
        if (silence_r != 16'd0) begin
          silence_nxt = silence_r - 16'd1;
        end else begin
          eflag_nxt   = 1'b1;
          silence_nxt = err_timeout_r;
        end
        if (reply_r != 16'd0) begin
          reply_nxt = reply_r - 16'd1;
          idle_nxt  = 8'd0;
          if (reply_r == 16'd1) begin
            rx_on_nxt = 1'b0;
            seq_nxt   = seq_r + 8'd1;
            send      = 1'b1;
          end
        end else begin
          idle_nxt = idle_r + 8'd1;
          if (idle_nxt >= idle_limit_r) begin
            idle_nxt  = 8'd0;
            reply_nxt = retry_delay_r;
          end
        end
        if (reen_nxt != 8'd0) begin
          reen_nxt = reen_nxt - 8'd1;
          if (reen_nxt == 8'd0) rx_on_nxt = 1'b1;
        end
      end
    end
    job.send           = send;
    job.speed_level    = item.speed_level;
    job.protect_level  = item.protect_level;
    job.send_seq       = seq_nxt;
    job.rx_enable      = rx_on_nxt;
    job.comm_error     = eflag_nxt;
    job.comp_error     = code_nxt;
    job.handshake_done = link_nxt;
    job.frame_accepted = pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r    <= 1'b0;
      seq_r     <= 8'd0;
      reply_r   <= RST_REPLY_COUNT;
      idle_r    <= 8'd0;
      silence_r <= RST_ERROR_TIMEOUT;
      reen_r    <= 8'd0;
      idx_r     <= '0;
      crc_r     <= 8'd0;
      c7_r      <= 8'd0;
      c9_r      <= 8'd0;
      eflag_r   <= 1'b0;
      code_r    <= 3'd0;
      rx_on_r   <= 1'b1;
    end else begin
      link_r    <= link_nxt;
      seq_r     <= seq_nxt;
      reply_r   <= reply_nxt;
      idle_r    <= idle_nxt;
      silence_r <= silence_nxt;
      reen_r    <= reen_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      c7_r      <= c7_nxt;
      c9_r      <= c9_nxt;
      eflag_r   <= eflag_nxt;
      code_r    <= code_nxt;
      rx_on_r   <= rx_on_nxt;
    end
  end

  // Frame bytes carry no reset; they are judged only once written.
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

endmodule

/* hdl/cle_queue.sv */
module cle_queue import cle_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

/* hdl/cle_back.sv */
module cle_back import cle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  job_t       job_r;
  logic       busy_r;
  logic [2:0] k_r;
  logic [7:0] crc_r;
  logic [7:0] fbyte;
  logic       last, load;

  // Frame byte at position k, before the trailing CRC.
  always_comb begin
    fbyte = 8'h00;
    case (k_r)
      3'd0: fbyte = SOF_TX;
      3'd1: fbyte = job_r.handshake_done ? ID_DATA : ID_HS;
      3'd2: fbyte = LEN_HS;
      3'd3: fbyte = (job_r.handshake_done && job_r.speed_level != SPEED_STOP) ? 8'h01 : 8'h00;
      3'd4: begin
        if (job_r.handshake_done) begin
          case (job_r.speed_level)
            SPEED_MAX:  fbyte = SPD_MAX;
            SPEED_ECO:  fbyte = SPD_ECO;
            SPEED_MAX4: fbyte = SPD_MAX4;
            default:    fbyte = SPD_OTHER;
          endcase
        end
      end
      3'd5: fbyte = job_r.handshake_done ? DATA_FILL : 8'h00;
      3'd6: begin
        if (job_r.handshake_done) begin
          case (job_r.protect_level)
            PROT_CODE_LOW: fbyte = PROT_LOW;
            PROT_CODE_MID: fbyte = PROT_MID;
            default:       fbyte = PROT_HIGH;
          endcase
        end
      end
      default: fbyte = 8'h00;
    endcase
  end

  assign last      = !job_r.send || (k_r == TX_LAST_POS);
  assign out_empty = !busy_r;
  assign load      = !busy_r || (out_pop && last);
  assign q_pop     = load && !q_empty;

  always_comb begin
    out_item.tx_valid       = job_r.send;
    out_item.tx_byte        = !job_r.send ? 8'h00 : ((k_r == TX_LAST_POS) ? crc_r : fbyte);
    out_item.tx_last        = last;
    out_item.send_seq       = job_r.send_seq;
    out_item.rx_enable      = job_r.rx_enable;
    out_item.comm_error     = job_r.comm_error;
    out_item.comp_error     = job_r.comp_error;
    out_item.handshake_done = job_r.handshake_done;
    out_item.frame_accepted = job_r.frame_accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 3'd0;
      crc_r  <= 8'd0;
    end else if (load) begin
      busy_r <= !q_empty;
      k_r    <= 3'd0;
      crc_r  <= 8'd0;
    end else if (out_pop) begin
      k_r    <= k_r + 3'd1;
      crc_r  <= crc_step(crc_r, fbyte);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
  end

endmodule
